// ===== design/pipe_byte_fifo_with_end_counts_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pipe byte FIFO checker
// Concurrent assertion shorthands, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PIPE_BYTE_FIFO_WITH_END_COUNTS_ASSERT_SVH
`define PIPE_BYTE_FIFO_WITH_END_COUNTS_ASSERT_SVH

// Same-cycle implication
`define PBFEC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pbfec assertion failed");

// Next-cycle implication
`define PBFEC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pbfec assertion failed");

`endif

// ===== design/pbfec_pkg.sv =====
// ----------------------------------------------------------------------------
// pbfec_pkg
// Shared codes, widths and types of the pipe byte FIFO.
// ----------------------------------------------------------------------------
package pbfec_pkg;

    // Default sizes
    localparam int DEPTH_DEF    = 4096;
    localparam int CNT_BITS_DEF = 16;

    // Result field widths
    localparam int BYTES_W = 13;
    localparam int CNT_W   = 16;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 72;

    // Commands
    localparam logic [2:0] CMD_OPEN  = 3'd0;
    localparam logic [2:0] CMD_REF   = 3'd1;
    localparam logic [2:0] CMD_CLOSE = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // End select
    localparam logic END_READ  = 1'b0;
    localparam logic END_WRITE = 1'b1;

    // Register index
    localparam logic REG_NAMED_FIFO = 1'b0;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_BLOCK = 2'd1,
        ST_EOF   = 2'd2,
        ST_EPIPE = 2'd3
    } t_status;

    // One result, less the byte read from the ring
    typedef struct packed {
        t_status              status;
        logic                 rd_ok;
        logic [BYTES_W-1:0]   bytes_in_call;
        logic [BYTES_W-1:0]   fill_level;
        logic [CNT_W-1:0]     readers_open;
        logic [CNT_W-1:0]     writers_open;
        logic                 read_end_closed;
        logic                 write_end_closed;
        logic                 released;
    } t_result;

endpackage

// ===== design/pbfec_ring.sv =====
// ----------------------------------------------------------------------------
// pbfec_ring
// Byte ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pbfec_ring #(
    parameter int DEPTH = pbfec_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Write the new byte at the tail
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the byte at the head
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pbfec_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbfec_ctrl
// Pipe bookkeeping: ring pointers, fill, end and reference counters, flags.
// ----------------------------------------------------------------------------
module pbfec_ctrl #(
    parameter int DEPTH    = pbfec_pkg::DEPTH_DEF,
    parameter int CNT_BITS = pbfec_pkg::CNT_BITS_DEF,
    parameter int AW       = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [2:0]          i_cmd,
    input  logic                i_end_sel,
    input  logic                i_last,
    input  logic                i_named,
    output logic                o_mem_we,
    output logic [AW-1:0]       o_tail,
    output logic [AW-1:0]       o_head,
    output pbfec_pkg::t_result  o_res
);

    localparam int OW   = $clog2(DEPTH + 1);
    localparam int FW   = (OW > pbfec_pkg::BYTES_W) ? OW : pbfec_pkg::BYTES_W;
    localparam int RW   = (CNT_BITS > pbfec_pkg::CNT_W) ? CNT_BITS : pbfec_pkg::CNT_W;
    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};
    localparam logic [OW-1:0]       OCC_MAX = OW'(DEPTH);
    localparam logic [AW-1:0]       IDX_TOP = AW'(DEPTH - 1);

    logic [AW-1:0]       r_head,  n_head;
    logic [AW-1:0]       r_tail,  n_tail;
    logic [OW-1:0]       r_occ,   n_occ;
    logic [CNT_BITS-1:0] r_rdrs,  n_rdrs;
    logic [CNT_BITS-1:0] r_wrts,  n_wrts;
    logic [CNT_BITS-1:0] r_refs,  n_refs;
    logic                r_rclo,  n_rclo;
    logic                r_wclo,  n_wclo;
    logic [OW-1:0]       r_prog,  n_prog;

    pbfec_pkg::t_status  status;
    logic                rd_ok;
    logic                moved;
    logic                byte_cmd;
    logic                released;
    logic [OW-1:0]       prog_out;
    logic [FW-1:0]       prog_w;
    logic [FW-1:0]       occ_w;
    logic [RW-1:0]       rdrs_w;
    logic [RW-1:0]       wrts_w;

    // Work out the effect of one command
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_occ    = r_occ;
        n_rdrs   = r_rdrs;
        n_wrts   = r_wrts;
        n_refs   = r_refs;
        n_rclo   = r_rclo;
        n_wclo   = r_wclo;
        status   = pbfec_pkg::ST_DONE;
        rd_ok    = 1'b0;
        moved    = 1'b0;
        byte_cmd = 1'b0;
        released = 1'b0;
        o_mem_we = 1'b0;
        case (i_cmd)
            pbfec_pkg::CMD_OPEN: begin
                n_refs = (r_refs == CNT_MAX) ? r_refs : r_refs + 1'b1;
                if (i_end_sel == pbfec_pkg::END_READ) begin
                    n_rdrs = (r_rdrs == CNT_MAX) ? r_rdrs : r_rdrs + 1'b1;
                    if (i_named) begin
                        n_rclo = 1'b0;
                    end
                end else begin
                    n_wrts = (r_wrts == CNT_MAX) ? r_wrts : r_wrts + 1'b1;
                    if (i_named) begin
                        n_wclo = 1'b0;
                    end
                end
            end
            pbfec_pkg::CMD_REF: begin
                n_refs = (r_refs == CNT_MAX) ? r_refs : r_refs + 1'b1;
            end
            pbfec_pkg::CMD_CLOSE: begin
                if (i_end_sel == pbfec_pkg::END_READ) begin
                    n_rdrs = (r_rdrs != '0) ? r_rdrs - 1'b1 : r_rdrs;
                    n_rclo = 1'b1;
                end else begin
                    n_wrts = (r_wrts != '0) ? r_wrts - 1'b1 : r_wrts;
                    n_wclo = 1'b1;
                end
                if (r_refs != '0) begin
                    n_refs   = r_refs - 1'b1;
                    released = (r_refs == CNT_BITS'(1)) && !i_named;
                end
            end
            pbfec_pkg::CMD_WRITE: begin
                byte_cmd = 1'b1;
                if (r_rdrs == '0) begin
                    status = pbfec_pkg::ST_EPIPE;
                end else if (r_occ >= OCC_MAX) begin
                    status = pbfec_pkg::ST_BLOCK;
                end else begin
                    o_mem_we = 1'b1;
                    n_tail   = (r_tail == IDX_TOP) ? '0 : r_tail + 1'b1;
                    n_occ    = r_occ + 1'b1;
                    moved    = 1'b1;
                end
            end
            pbfec_pkg::CMD_READ: begin
                byte_cmd = 1'b1;
                if (r_occ == '0) begin
                    status = (r_wrts == '0) ? pbfec_pkg::ST_EOF : pbfec_pkg::ST_BLOCK;
                end else begin
                    rd_ok  = 1'b1;
                    n_head = (r_head == IDX_TOP) ? '0 : r_head + 1'b1;
                    n_occ  = r_occ - 1'b1;
                    moved  = 1'b1;
                end
            end
            default: begin
            end
        endcase
        // Count the byte into the call, then close the call on its last item
        prog_out = (moved && (r_prog < OCC_MAX)) ? r_prog + 1'b1 : r_prog;
        n_prog   = (byte_cmd && i_last) ? '0 : prog_out;
    end

    // Mask the counters to the result field widths
    assign prog_w = FW'(prog_out);
    assign occ_w  = FW'(n_occ);
    assign rdrs_w = RW'(n_rdrs);
    assign wrts_w = RW'(n_wrts);

    always_comb begin
        o_res.status           = status;
        o_res.rd_ok            = rd_ok;
        o_res.bytes_in_call    = prog_w[pbfec_pkg::BYTES_W-1:0];
        o_res.fill_level       = occ_w[pbfec_pkg::BYTES_W-1:0];
        o_res.readers_open     = rdrs_w[pbfec_pkg::CNT_W-1:0];
        o_res.writers_open     = wrts_w[pbfec_pkg::CNT_W-1:0];
        o_res.read_end_closed  = n_rclo;
        o_res.write_end_closed = n_wclo;
        o_res.released         = released;
    end

    // Advance the state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
            r_rdrs <= '0;
            r_wrts <= '0;
            r_refs <= '0;
            r_rclo <= 1'b0;
            r_wclo <= 1'b0;
            r_prog <= '0;
        end else if (i_accept) begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_occ  <= n_occ;
            r_rdrs <= n_rdrs;
            r_wrts <= n_wrts;
            r_refs <= n_refs;
            r_rclo <= n_rclo;
            r_wclo <= n_wclo;
            r_prog <= n_prog;
        end
    end

    assign o_head = r_head;
    assign o_tail = r_tail;

endmodule

// ===== design/pipe_byte_fifo_with_end_counts.sv =====
// ----------------------------------------------------------------------------
// pipe_byte_fifo_with_end_counts
// Byte FIFO with pipe semantics: end and reference counting, byte I/O.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the slave stream: tuser carries the command and the end
//   select, tdata the byte to write, tlast marks the final byte of one call.
//   Each request gives exactly one result on the master stream, carrying the
//   status, the byte read, the bytes moved in the call, the fill level, the
//   open end counts, the closed flags and the release flag.
//   tvalid rises in the cycle after acceptance; one request is taken per
//   cycle while the receiver does not stall, set by the single result
//   register and the ring's one write and one registered read port.
//   While the receiver stalls the result is held and a new request is taken
//   only in the cycle the held result leaves.
//   Reset clears the pointers, counters, flags and named_fifo; the ring
//   content stays undefined and gets no clearing pass, so requests are taken
//   from the first cycle after reset.
//   named_fifo sits at APB byte address 0; the user writes it only while idle (not enforced by the block).
// ----------------------------------------------------------------------------
module pipe_byte_fifo_with_end_counts #(
    parameter int DEPTH    = pbfec_pkg::DEPTH_DEF,
    parameter int CNT_BITS = pbfec_pkg::CNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Request stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata: write_data[7:0]
    input  logic [pbfec_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // tuser: cmd[2:0], end_select[3]
    input  logic [pbfec_pkg::S_TUSER_W-1:0]   i_s_tuser,
    input  logic                              i_s_tlast,
    // Result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata: status[1:0], read_data[9:2], bytes_in_call[22:10],
    //        fill_level[35:23], readers_open[51:36], writers_open[67:52],
    //        read_end_closed[68], write_end_closed[69], released[70], zero[71]
    output logic [pbfec_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // Configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int AW = $clog2(DEPTH);

    logic                r_named;
    logic                r_m_valid;
    pbfec_pkg::t_result  r_res;
    pbfec_pkg::t_result  n_res;
    logic                accept;
    logic                mem_we;
    logic [AW-1:0]       tail;
    logic [AW-1:0]       head;
    logic [7:0]          rdata;
    logic [7:0]          read_byte;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_named <= 1'b0;
        end else if (psel && penable && pwrite && (paddr[2] == pbfec_pkg::REG_NAMED_FIFO)) begin
            r_named <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == pbfec_pkg::REG_NAMED_FIFO) ? {31'd0, r_named} : 32'd0;

    // Take a request when the result register is free or emptying
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    pbfec_ctrl #(
        .DEPTH    (DEPTH),
        .CNT_BITS (CNT_BITS),
        .AW       (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_cmd     (i_s_tuser[2:0]),
        .i_end_sel (i_s_tuser[3]),
        .i_last    (i_s_tlast),
        .i_named   (r_named),
        .o_mem_we  (mem_we),
        .o_tail    (tail),
        .o_head    (head),
        .o_res     (n_res)
    );

    pbfec_ring #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (accept && mem_we),
        .i_waddr (tail),
        .i_wdata (i_s_tdata[7:0]),
        .i_re    (accept),
        .i_raddr (head),
        .o_rdata (rdata)
    );

    // Result register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (accept) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    // Pack the result
    assign read_byte  = r_res.rd_ok ? rdata : 8'd0;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {1'b0,
                         r_res.released,
                         r_res.write_end_closed,
                         r_res.read_end_closed,
                         r_res.writers_open,
                         r_res.readers_open,
                         r_res.fill_level,
                         r_res.bytes_in_call,
                         read_byte,
                         r_res.status};

endmodule

// ===== design/pbfec_checker.sv =====
// ----------------------------------------------------------------------------
// pbfec_checker
// Port-level checks of the pipe byte FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "pipe_byte_fifo_with_end_counts_assert.svh"

module pbfec_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [pbfec_pkg::M_TDATA_W-1:0]   o_m_tdata
);

    // A stalled result holds
    `PBFEC_ASSERT_NXT(a_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // An empty result register takes a request
    `PBFEC_ASSERT_IMP(a_ready_empty, !o_m_tvalid, o_s_tready)

    // Every accepted request shows a result next cycle
    `PBFEC_ASSERT_NXT(a_result, i_s_tvalid && o_s_tready, o_m_tvalid)

    // A byte is returned only with status done
    `PBFEC_ASSERT_IMP(a_rdata_done, o_m_tvalid && (o_m_tdata[1:0] != pbfec_pkg::ST_DONE), o_m_tdata[9:2] == 8'd0)

    // Release comes only from a close, which sets a closed flag
    `PBFEC_ASSERT_IMP(a_release, o_m_tvalid && o_m_tdata[70], (o_m_tdata[68] || o_m_tdata[69]) && (o_m_tdata[1:0] == pbfec_pkg::ST_DONE))

endmodule

bind pipe_byte_fifo_with_end_counts pbfec_checker u_pbfec_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
